// ----- hw/rtl/dtc_pkg.sv -----
// Shared types and constants for the decreasing triplet counter.
// Used by dtc_ctrl, dtc_datapath and the top level; depends on nothing.
`default_nettype none

package dtc_pkg;

    // Sequence capacity and the widths that follow from it
    localparam int MAX_N   = 1024;
    localparam int VAL_W   = 11;                           // input value field
    localparam int CNT_W   = $clog2(MAX_N + 1);            // counts, values, tree address
    localparam int IDX_W   = CNT_W + 1;                    // tree walk index (update overshoot)
    localparam int SA_W    = $clog2(MAX_N);                // store address
    localparam int GB_W    = SA_W;                         // earlier-greater count
    localparam int PROD_W  = GB_W + CNT_W;
    localparam int TOT_W   = 28;
    localparam int SUM_W   = ((PROD_W > TOT_W) ? PROD_W : TOT_W) + 1;
    localparam int STORE_W = GB_W + CNT_W;

    localparam logic [CNT_W-1:0] MAX_POS   = CNT_W'(MAX_N);
    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    typedef enum logic [3:0] {
        S_CLR_INIT,
        S_IDLE,
        S_LQS,
        S_LQ_WAIT,
        S_LSTORE,
        S_LU_WAIT,
        S_CLR_MID,
        S_RCHK,
        S_RDATA,
        S_RQ_WAIT,
        S_RMUL,
        S_RADD,
        S_RU_WAIT,
        S_RFIN,
        S_CLR_END
    } dtc_state_t;

    typedef enum logic [1:0] {
        POS_LOAD,
        POS_XM1,
        POS_X
    } dtc_pos_t;

    typedef struct packed {
        logic     capture;
        logic     clear;
        logic     q_start;
        logic     u_start;
        dtc_pos_t pos_sel;
        logic     ld_store;
        logic     ovf_set;
        logic     rev_init;
        logic     rev_read;
        logic     mul;
        logic     add;
        logic     out_load;
    } dtc_cmd_t;

    typedef struct packed {
        logic walk_busy;
        logic sweep_done;
        logic cnt_full;
        logic rev_zero;
        logic out_full;
        logic last;
    } dtc_sts_t;

    // Saturate an input value into 1..MAX_N
    function automatic logic [CNT_W-1:0] clamp_value(input logic [VAL_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (32'(v) > 32'(MAX_N)) begin
            r = MAX_POS;
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dtc_datapath.sv -----
// Datapath of the decreasing triplet counter: Fenwick tree memory and walk unit,
// value store, product and total registers, result register. Depends on dtc_pkg.
`default_nettype none

module dtc_datapath import dtc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [VAL_W-1:0]   s_value,
    input  logic               s_last,
    input  dtc_cmd_t           cmd,
    output dtc_sts_t           sts,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [TOT_W-1:0]   m_triplet_count,
    output logic               m_overflow
);

    logic [CNT_W-1:0]   val_reg;
    logic               last_reg;
    logic [CNT_W-1:0]   item_cnt_reg;
    logic               ovf_reg;
    logic [CNT_W-1:0]   sweep_reg;

    logic [IDX_W-1:0]   idx_reg;
    logic               upd_reg;
    logic               active_reg;
    logic               rd_valid_reg;
    logic [CNT_W-1:0]   rd_addr_reg;
    logic [CNT_W-1:0]   acc_reg;
    logic [CNT_W-1:0]   tree_rd_reg;

    logic [STORE_W-1:0] store_rd_reg;
    logic [CNT_W-1:0]   rev_idx_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [TOT_W-1:0]   total_next;

    logic               m_valid_reg;
    logic [TOT_W-1:0]   m_count_reg;
    logic               m_ovf_reg;

    logic [CNT_W-1:0]   tree_mem  [0:MAX_N];
    logic [STORE_W-1:0] store_mem [0:MAX_N-1];

    logic [CNT_W-1:0]   walk_pos;
    logic               walk_go;
    logic [IDX_W-1:0]   low_bit;
    logic [IDX_W-1:0]   step_idx;
    logic               step_more;
    logic [CNT_W-1:0]   store_x;
    logic [GB_W-1:0]    store_gb;
    logic [GB_W-1:0]    gb_new;
    logic [CNT_W-1:0]   rev_dec;
    logic [SUM_W-1:0]   sum;

    assign store_x  = store_rd_reg[CNT_W-1:0];
    assign store_gb = store_rd_reg[STORE_W-1 -: GB_W];
    assign gb_new   = GB_W'(item_cnt_reg - acc_reg);
    assign rev_dec  = rev_idx_reg - 1'b1;

    always_comb begin
        unique case (cmd.pos_sel)
            POS_LOAD: walk_pos = val_reg;
            POS_XM1:  walk_pos = store_x - 1'b1;
            POS_X:    walk_pos = store_x;
            default:  walk_pos = val_reg;
        endcase
    end

    assign walk_go   = (walk_pos != '0) && (walk_pos <= MAX_POS);
    assign low_bit   = idx_reg & (~idx_reg + 1'b1);
    assign step_idx  = upd_reg ? (idx_reg + low_bit) : (idx_reg - low_bit);
    assign step_more = upd_reg ? (step_idx <= IDX_W'(MAX_N)) : (step_idx != '0);

    // Input capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            val_reg  <= clamp_value(s_value);
            last_reg <= s_last;
        end
    end

    // Sequence bookkeeping and clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_cnt_reg <= '0;
            ovf_reg      <= 1'b0;
            sweep_reg    <= '0;
        end else begin
            if (cmd.out_load) begin
                item_cnt_reg <= '0;
                ovf_reg      <= 1'b0;
            end else begin
                if (cmd.ld_store) begin
                    item_cnt_reg <= item_cnt_reg + 1'b1;
                end
                if (cmd.ovf_set) begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.clear) begin
                sweep_reg <= (sweep_reg == MAX_POS) ? '0 : sweep_reg + 1'b1;
            end
        end
    end

    // Tree walk control: issue one read per cycle and act on the registered read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= active_reg;
            if (cmd.q_start || cmd.u_start) begin
                active_reg <= walk_go;
            end else if (active_reg) begin
                active_reg <= step_more;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= idx_reg[CNT_W-1:0];
        if (cmd.q_start || cmd.u_start) begin
            idx_reg <= {1'b0, walk_pos};
            upd_reg <= cmd.u_start;
        end else if (active_reg) begin
            idx_reg <= step_idx;
        end
        if (cmd.q_start) begin
            acc_reg <= '0;
        end else if (rd_valid_reg && !upd_reg) begin
            acc_reg <= acc_reg + tree_rd_reg;
        end
    end

    // Tree memory: one write port shared by the sweep and the update walk
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            tree_mem[sweep_reg] <= '0;
        end else if (rd_valid_reg && upd_reg) begin
            tree_mem[rd_addr_reg] <= tree_rd_reg + 1'b1;
        end
        tree_rd_reg <= tree_mem[idx_reg[CNT_W-1:0]];
    end

    // Value store: written in load order, read back in reverse
    always_ff @(posedge aclk) begin
        if (cmd.ld_store) begin
            store_mem[item_cnt_reg[SA_W-1:0]] <= {gb_new, val_reg};
        end
        if (cmd.rev_read) begin
            store_rd_reg <= store_mem[rev_dec[SA_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rev_init) begin
            rev_idx_reg <= item_cnt_reg;
        end else if (cmd.rev_read) begin
            rev_idx_reg <= rev_dec;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(store_gb) * PROD_W'(acc_reg);
        end
    end

    // Saturating running total
    assign sum = SUM_W'(total_reg) + SUM_W'(prod_reg);

    always_comb begin
        if (sum > SUM_W'(TOTAL_MAX)) begin
            total_next = TOTAL_MAX;
        end else begin
            total_next = sum[TOT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (cmd.out_load) begin
            total_reg <= '0;
        end else if (cmd.add) begin
            total_reg <= total_next;
        end
    end

    // Result register: hold the beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_count_reg <= total_reg;
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_triplet_count = m_count_reg;
    assign m_overflow      = m_ovf_reg;

    assign sts.walk_busy  = active_reg || rd_valid_reg;
    assign sts.sweep_done = (sweep_reg == MAX_POS);
    assign sts.cnt_full   = (item_cnt_reg == MAX_POS);
    assign sts.rev_zero   = (rev_idx_reg == '0);
    assign sts.out_full   = m_valid_reg;
    assign sts.last       = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dtc_ctrl.sv -----
// Controller of the decreasing triplet counter: sequences the load pass, the
// clearing sweeps and the reverse pass. Depends on dtc_pkg.
`default_nettype none

module dtc_ctrl import dtc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_last,
    output logic     s_ready,
    input  dtc_sts_t sts,
    output dtc_cmd_t cmd
);

    dtc_state_t state_reg;
    dtc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR_INIT: if (sts.sweep_done) state_next = S_IDLE;
            S_IDLE: begin
                if (s_valid) begin
                    if (!sts.cnt_full) begin
                        state_next = S_LQS;
                    end else if (s_last) begin
                        state_next = S_CLR_MID;
                    end
                end
            end
            S_LQS:      state_next = S_LQ_WAIT;
            S_LQ_WAIT:  if (!sts.walk_busy) state_next = S_LSTORE;
            S_LSTORE:   state_next = S_LU_WAIT;
            S_LU_WAIT: begin
                if (!sts.walk_busy) begin
                    state_next = sts.last ? S_CLR_MID : S_IDLE;
                end
            end
            S_CLR_MID:  if (sts.sweep_done) state_next = S_RCHK;
            S_RCHK:     state_next = sts.rev_zero ? S_RFIN : S_RDATA;
            S_RDATA:    state_next = S_RQ_WAIT;
            S_RQ_WAIT:  if (!sts.walk_busy) state_next = S_RMUL;
            S_RMUL:     state_next = S_RADD;
            S_RADD:     state_next = S_RU_WAIT;
            S_RU_WAIT:  if (!sts.walk_busy) state_next = S_RCHK;
            S_RFIN:     if (!sts.out_full) state_next = S_CLR_END;
            S_CLR_END:  if (sts.sweep_done) state_next = S_IDLE;
            default:    state_next = S_CLR_INIT;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.pos_sel = POS_LOAD;
        s_ready     = 1'b0;
        unique case (state_reg)
            S_CLR_INIT, S_CLR_END: cmd.clear = 1'b1;
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                cmd.ovf_set = s_valid && sts.cnt_full;
            end
            S_LQS:      cmd.q_start = 1'b1;
            S_LSTORE: begin
                cmd.ld_store = 1'b1;
                cmd.u_start  = 1'b1;
            end
            S_CLR_MID: begin
                cmd.clear    = 1'b1;
                cmd.rev_init = 1'b1;
            end
            S_RCHK:     cmd.rev_read = !sts.rev_zero;
            S_RDATA: begin
                cmd.q_start = 1'b1;
                cmd.pos_sel = POS_XM1;
            end
            S_RMUL: begin
                cmd.mul     = 1'b1;
                cmd.u_start = 1'b1;
                cmd.pos_sel = POS_X;
            end
            S_RADD:     cmd.add = 1'b1;
            S_RFIN:     cmd.out_load = !sts.out_full;
            S_LQ_WAIT, S_LU_WAIT, S_RQ_WAIT, S_RU_WAIT: ;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/decreasing_triplet_counter.sv -----
// Decreasing triplet counter: counts index triples i<j<k with a[i]>a[j]>a[k].
// Top level joining dtc_ctrl and dtc_datapath; depends on dtc_pkg.
//
// Input beats (s_value, s_last) carry one sequence element each; values are
// saturated into 1..MAX_N. The beat with s_last high closes the sequence, and
// one result beat (m_triplet_count, m_overflow) follows. Elements beyond MAX_N
// are dropped and raise m_overflow for that sequence.
// Each stored element takes one Fenwick query and one update on the shared
// single-port-read tree memory, one step per cycle: popcount(value) query steps
// and an update walk to the top of the tree, together at most log2(MAX_N)+2
// steps, plus handshake and hand-over states; s_ready stays low until both
// walks of one accepted beat are done. After the last beat the tree is swept
// clear, the stored elements are walked in reverse, the result is loaded, and
// the tree is swept again before s_ready returns.
// After reset a clearing pass over the tree runs with s_ready low.
// The result waits in an output register while m_ready is low; only the end
// of the next sequence's reverse pass holds until that beat is taken.
`default_nettype none

module decreasing_triplet_counter import dtc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [VAL_W-1:0] s_value,
    input  logic             s_last,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [TOT_W-1:0] m_triplet_count,
    output logic             m_overflow
);

    dtc_cmd_t cmd;
    dtc_sts_t sts;

    dtc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dtc_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_value         (s_value),
        .s_last          (s_last),
        .cmd             (cmd),
        .sts             (sts),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_triplet_count (m_triplet_count),
        .m_overflow      (m_overflow)
    );

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid)
        else $error("result loaded over an untaken beat");

    a_walk_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.q_start || cmd.u_start) |-> !sts.walk_busy)
        else $error("tree walk started while another is running");

    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !sts.walk_busy)
        else $error("tree sweep overlaps a tree walk");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !sts.walk_busy && !cmd.clear)
        else $error("input ready while the tree is in use");

endmodule

`default_nettype wire

// ----- tb/triplet_count_checker.sv -----
// Checker for the decreasing triplet counter: watches both channels, predicts
// each result beat from the accepted input beats and compares field by field.
// Depends on dtc_pkg for widths and MAX_N.
module triplet_count_checker import dtc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [VAL_W-1:0] s_value,
    input  logic             s_last,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [TOT_W-1:0] m_triplet_count,
    input  logic             m_overflow,
    output int               mismatches,
    output int               pending
);

    typedef struct packed {
        logic [TOT_W-1:0] count;
        logic             ovf;
    } triplet_result_t;

    triplet_result_t  triplet_q[$];
    logic [CNT_W-1:0] seq_value [MAX_N];
    logic [GB_W-1:0]  earlier_greater [MAX_N];
    int               loaded;
    logic             extra_seen;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic [CNT_W-1:0] saturate_value(input logic [VAL_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (int'(v) > MAX_N) begin
            r = CNT_W'(MAX_N);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    // Sum over each element of (earlier greater) * (later smaller), saturating
    function automatic logic [TOT_W-1:0] count_triplets();
        longint unsigned sum;
        int unsigned     smaller_after;
        sum = 0;
        for (int i = loaded - 1; i >= 0; i--) begin
            smaller_after = 0;
            for (int j = i + 1; j < loaded; j++) begin
                if (seq_value[j] < seq_value[i]) smaller_after++;
            end
            sum += longint'(earlier_greater[i]) * smaller_after;
            if (sum > longint'(TOTAL_MAX)) sum = longint'(TOTAL_MAX);
        end
        return TOT_W'(sum);
    endfunction

    always @(posedge aclk) begin : watch
        triplet_result_t  got;
        triplet_result_t  want;
        logic [CNT_W-1:0] v;
        int               above;
        if (!aresetn) begin
            loaded     = 0;
            extra_seen = 1'b0;
            triplet_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.count = m_triplet_count;
                got.ovf   = m_overflow;
                if (triplet_q.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d/%0b with no sequence closed",
                                              got.count, got.ovf));
                end else begin
                    want = triplet_q.pop_front();
                    if (got.count !== want.count)
                        report_mismatch($sformatf("triplet_count %0d, predicted %0d",
                                                  got.count, want.count));
                    if (got.ovf !== want.ovf)
                        report_mismatch($sformatf("overflow %0b, predicted %0b",
                                                  got.ovf, want.ovf));
                end
            end
            if (s_valid && s_ready) begin
                v = saturate_value(s_value);
                // drop beats once the store is full, but remember they came
                if (loaded < MAX_N) begin
                    above = 0;
                    for (int k = 0; k < loaded; k++) begin
                        if (seq_value[k] > v) above++;
                    end
                    earlier_greater[loaded] = GB_W'(above);
                    seq_value[loaded]       = v;
                    loaded++;
                end else begin
                    extra_seen = 1'b1;
                end
                if (s_last) begin
                    want.count = count_triplets();
                    want.ovf   = extra_seen;
                    triplet_q.insert(triplet_q.size(), want);
                    loaded     = 0;
                    extra_seen = 1'b0;
                end
            end
        end
        pending = triplet_q.size();
    end

endmodule

// ----- tb/tb_decreasing_triplet_counter.sv -----
// Testbench top for the decreasing triplet counter: drives sequences of
// values with bursty valid and a stalling receiver; triplet_count_checker judges.
// Depends on dtc_pkg, decreasing_triplet_counter and triplet_count_checker.
module tb_decreasing_triplet_counter;
    import dtc_pkg::*;

    localparam int RUN_LIMIT   = 12000000;
    localparam int ITEM_TARGET = 1450;

    typedef enum int {
        SHAPE_UNIFORM,
        SHAPE_FALLING,
        SHAPE_NARROW
    } seq_shape_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [VAL_W-1:0] s_value;
    logic             s_last;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [TOT_W-1:0] m_triplet_count;
    logic             m_overflow;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int burst_left;
    int items_sent;
    int stall_left = 0;
    int calm_left = 0;

    decreasing_triplet_counter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_triplet_count (m_triplet_count),
        .m_overflow      (m_overflow)
    );

    triplet_count_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_triplet_count (m_triplet_count),
        .m_overflow      (m_overflow),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random stalls, broken by long stretches of steady ready
    always @(negedge aclk) begin
        if (calm_left > 0) begin
            calm_left--;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2: stall_left = $urandom_range(1, 30);
                3:       calm_left  = $urandom_range(50, 2000);
                default: ;
            endcase
        end
    end

    // Offer one beat and hold it until taken; often open a gap between bursts
    task automatic send_beat(input logic [VAL_W-1:0] v, input logic l);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_value <= v;
        s_last  <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    function automatic logic [VAL_W-1:0] next_value(input seq_shape_t shape,
                                                    input int idx, input int len);
        int v;
        int stride;
        case (shape)
            SHAPE_FALLING: begin
                // mostly descending, to push the count towards its widest values
                stride = (len >= MAX_N) ? 1 : MAX_N / len;
                v = MAX_N - idx * stride - int'($urandom_range(0, stride - 1));
                if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 2047);
                if (v < 0) v = $urandom_range(0, 2);
            end
            SHAPE_NARROW: begin
                v = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            end
            default: begin
                case ($urandom_range(0, 9))
                    0:       v = 0;
                    1:       v = $urandom_range(MAX_N + 1, 2047);
                    default: v = $urandom_range(1, MAX_N);
                endcase
            end
        endcase
        return VAL_W'(v);
    endfunction

    task automatic send_sequence(input seq_shape_t shape, input int len);
        for (int i = 0; i < len; i++) begin
            send_beat(next_value(shape, i, len), i == len - 1);
        end
    endtask

    task automatic send_random_sequence();
        int r;
        int len;
        r = $urandom_range(0, 19);
        if (r < 16)      len = $urandom_range(1, 24);
        else if (r < 19) len = $urandom_range(25, 120);
        else             len = $urandom_range(121, 300);
        send_sequence(seq_shape_t'($urandom_range(0, 2)), len);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_value     = '0;
        s_last      = 1'b0;
        burst_left  = 0;
        items_sent  = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // lone element, zero saturates up to one
        send_beat(11'd0, 1'b1);
        // values above the range collapse onto MAX_N and tie
        send_beat(11'd2047, 1'b0);
        send_beat(11'd1025, 1'b0);
        send_beat(11'd1024, 1'b1);
        // strict fall through both saturation limits
        send_beat(11'd1500, 1'b0);
        send_beat(11'd1023, 1'b0);
        send_beat(11'd512, 1'b0);
        send_beat(11'd2, 1'b0);
        send_beat(11'd0, 1'b1);
        // duplicates must not count as decreasing
        send_beat(11'd5, 1'b0);
        send_beat(11'd5, 1'b0);
        send_beat(11'd3, 1'b0);
        send_beat(11'd3, 1'b0);
        send_beat(11'd1, 1'b1);
        // rising run gives nothing
        send_beat(11'd1, 1'b0);
        send_beat(11'd2, 1'b0);
        send_beat(11'd3, 1'b1);
        // interleaved
        send_beat(11'd9, 1'b0);
        send_beat(11'd4, 1'b0);
        send_beat(11'd7, 1'b0);
        send_beat(11'd2, 1'b0);
        send_beat(11'd8, 1'b0);
        send_beat(11'd1, 1'b1);

        while (items_sent < 250) send_random_sequence();
        // fill the store and run past it, closing on a dropped beat
        send_sequence(SHAPE_FALLING, MAX_N + $urandom_range(1, 4));
        while (items_sent < ITEM_TARGET) send_random_sequence();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        // let the closing sweep run out
        repeat (2 * (MAX_N + 1) + 200) @(negedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
